[design/assert_macros.svh]
// Assertion macros shared by the partition mismatch scoring RTL.
// Each macro wraps one clocked concurrent assertion with reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PMS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold at the same edge as the antecedent.
`define PMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold at the edge after the antecedent.
`define PMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/pms_pkg.sv]
// Shared types and constants of the partition mismatch scoring block.
// No dependencies; imported by pms_cost and the top level.
package pms_pkg;

    localparam int NUM_PARTS   = 4;
    localparam int BITMAP_W    = 64;
    localparam int PART_CNT_W  = 3;
    localparam int SCORE_W     = 8;
    localparam int CHUNK_W     = 16;
    localparam int NUM_CHUNKS  = BITMAP_W / CHUNK_W;
    localparam int CHUNK_CNT_W = $clog2(CHUNK_W + 1);
    localparam int COST_W      = $clog2(BITMAP_W + 1);
    localparam int TOTAL_W     = $clog2(NUM_PARTS * BITMAP_W + 1);
    localparam int NUM_PERMS   = 24;
    localparam int NUM_GROUPS  = 4;
    localparam int GROUP_SIZE  = NUM_PERMS / NUM_GROUPS;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = BITMAP_W;

    localparam logic [PART_CNT_W-1:0] MIN_PARTS     = 3'd2;
    localparam logic [PART_CNT_W-1:0] MAX_PARTS     = 3'd4;
    localparam logic [SCORE_W-1:0]    NO_MATCH_SCORE = 8'd255;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BLOCK_PARTITIONS = 3'd0,
        REG_BLOCK_BITMAP_0   = 3'd1,
        REG_BLOCK_BITMAP_1   = 3'd2,
        REG_BLOCK_BITMAP_2   = 3'd3,
        REG_BLOCK_BITMAP_3   = 3'd4
    } cfg_reg_t;

    typedef logic [BITMAP_W-1:0]                 bitmap_t;
    typedef bitmap_t [NUM_PARTS-1:0]             bitmap_set_t;
    typedef logic [COST_W-1:0]                   cost_t;
    typedef cost_t [NUM_PARTS-1:0][NUM_PARTS-1:0] cost_mat_t;
    typedef logic [TOTAL_W-1:0]                  total_t;

    // Per-word sideband that rides along the pipeline.
    typedef struct packed {
        logic                  no_match;
        logic [PART_CNT_W-1:0] parts;
    } meta_t;

    // All orderings of four partitions; entry [k][i] is the table partition
    // matched to block partition i.
    localparam logic [1:0] PERM_TABLE [NUM_PERMS][NUM_PARTS] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd3, 2'd2}, '{2'd0, 2'd2, 2'd1, 2'd3},
        '{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd0, 2'd3, 2'd1, 2'd2}, '{2'd0, 2'd3, 2'd2, 2'd1},
        '{2'd1, 2'd0, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd1, 2'd2, 2'd0, 2'd3},
        '{2'd1, 2'd2, 2'd3, 2'd0}, '{2'd1, 2'd3, 2'd0, 2'd2}, '{2'd1, 2'd3, 2'd2, 2'd0},
        '{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd2, 2'd0, 2'd3, 2'd1}, '{2'd2, 2'd1, 2'd0, 2'd3},
        '{2'd2, 2'd1, 2'd3, 2'd0}, '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd2, 2'd3, 2'd1, 2'd0},
        '{2'd3, 2'd0, 2'd1, 2'd2}, '{2'd3, 2'd0, 2'd2, 2'd1}, '{2'd3, 2'd1, 2'd0, 2'd2},
        '{2'd3, 2'd1, 2'd2, 2'd0}, '{2'd3, 2'd2, 2'd0, 2'd1}, '{2'd3, 2'd2, 2'd1, 2'd0}
    };

endpackage

[design/partition_mismatch_scoring_unit.sv]
// Partition mismatch scoring unit: least Hamming mismatch of a partition table
// entry against the block clustering over all partition matchings.
// Depends on pms_pkg, pms_cost and assert_macros.svh.
// Usage:
//   Write block_partitions (index 0) and block bitmaps 0..3 (index 1..4) through
//   cfg_we/cfg_index/cfg_wdata while no word is in flight; other indexes drop.
//   Stream table entries on s_t*; each accepted word yields one m_t* word with
//   the score (255 when the entry's partition count differs from the block's
//   or the block count is outside 2..4; totals above 255 saturate to 255).
// Timing:
//   Five register stages: chunk popcount, pair cost, permutation totals,
//   group minimum, final minimum. One word per cycle sustained while
//   m_tready stays high.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline, sets the block
//   partition count to 2 and clears all block bitmaps.
// Backpressure:
//   Each stage holds while the next is full and stalled; bubbles collapse, so
//   s_tready stays high until every stage holds a word behind a stalled
//   m_tready.
`include "assert_macros.svh"

module partition_mismatch_scoring_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [pms_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pms_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: [2:0] entry_partitions, [66:3] entry_bitmap_0, [130:67] entry_bitmap_1,
    //          [194:131] entry_bitmap_2, [258:195] entry_bitmap_3, [263:259] zero
    input  logic [263:0]                       s_tdata,
    // Result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: [7:0] mismatch_count
    output logic [pms_pkg::SCORE_W-1:0]        m_tdata
);
    import pms_pkg::*;

    localparam int ENTRY_LSB = PART_CNT_W;

    // Configuration registers
    logic [PART_CNT_W-1:0] block_partitions_reg;
    bitmap_set_t           block_bitmap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_partitions_reg <= MIN_PARTS;
            block_bitmap_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BLOCK_PARTITIONS: block_partitions_reg <= cfg_wdata[PART_CNT_W-1:0];
                REG_BLOCK_BITMAP_0:   block_bitmap_reg[0] <= cfg_wdata;
                REG_BLOCK_BITMAP_1:   block_bitmap_reg[1] <= cfg_wdata;
                REG_BLOCK_BITMAP_2:   block_bitmap_reg[2] <= cfg_wdata;
                REG_BLOCK_BITMAP_3:   block_bitmap_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input unpack and count check
    logic [PART_CNT_W-1:0] entry_partitions;
    bitmap_set_t           entry_bitmap;
    meta_t                 in_meta;

    always_comb begin
        entry_partitions = s_tdata[PART_CNT_W-1:0];
        for (int j = 0; j < NUM_PARTS; j++) begin
            entry_bitmap[j] = s_tdata[ENTRY_LSB + j*BITMAP_W +: BITMAP_W];
        end
        in_meta.parts    = block_partitions_reg;
        in_meta.no_match = (entry_partitions != block_partitions_reg)
                        || (block_partitions_reg < MIN_PARTS)
                        || (block_partitions_reg > MAX_PARTS);
    end

    // Cost matrix (stages 1 and 2)
    logic      cost_valid, cost_ready;
    meta_t     cost_meta;
    cost_mat_t cost;

    pms_cost u_cost (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_meta      (in_meta),
        .entry_bitmap (entry_bitmap),
        .block_bitmap (block_bitmap_reg),
        .out_valid    (cost_valid),
        .out_ready    (cost_ready),
        .out_meta     (cost_meta),
        .cost         (cost)
    );

    // Stage control
    logic s3_valid_reg, s3_valid_next;
    logic s4_valid_reg, s4_valid_next;
    logic s5_valid_reg, s5_valid_next;
    logic s3_ready, s4_ready, s5_ready;

    assign s5_ready   = !s5_valid_reg || m_tready;
    assign s4_ready   = !s4_valid_reg || s5_ready;
    assign s3_ready   = !s3_valid_reg || s4_ready;
    assign cost_ready = s3_ready;

    always_comb begin
        s3_valid_next = s3_ready ? cost_valid   : s3_valid_reg;
        s4_valid_next = s4_ready ? s3_valid_reg : s4_valid_reg;
        s5_valid_next = s5_ready ? s4_valid_reg : s5_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
            s5_valid_reg <= s5_valid_next;
        end
    end

    // Stage 3: total per ordering; orderings that move an unused partition
    // or pull in one beyond the count get the all-ones mark.
    total_t perm_total [NUM_PERMS];

    always_comb begin
        logic   usable;
        total_t sum;
        logic [1:0] p;
        for (int k = 0; k < NUM_PERMS; k++) begin
            usable = 1'b1;
            sum    = '0;
            for (int i = 0; i < NUM_PARTS; i++) begin
                p = PERM_TABLE[k][i];
                if (PART_CNT_W'(i) < cost_meta.parts) begin
                    if ({1'b0, p} >= cost_meta.parts) begin
                        usable = 1'b0;
                    end
                    sum = sum + total_t'(cost[i][p]);
                end else if (p != 2'(i)) begin
                    usable = 1'b0;
                end
            end
            perm_total[k] = usable ? sum : '1;
        end
    end

    meta_t  s3_meta_reg;
    total_t s3_total_reg [NUM_PERMS];

    always_ff @(posedge aclk) begin
        if (s3_ready && cost_valid) begin
            s3_meta_reg  <= cost_meta;
            s3_total_reg <= perm_total;
        end
    end

    // Stage 4: minimum within each group of orderings
    total_t group_min [NUM_GROUPS];

    always_comb begin
        total_t m;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            m = s3_total_reg[g*GROUP_SIZE];
            for (int e = 1; e < GROUP_SIZE; e++) begin
                if (s3_total_reg[g*GROUP_SIZE + e] < m) begin
                    m = s3_total_reg[g*GROUP_SIZE + e];
                end
            end
            group_min[g] = m;
        end
    end

    meta_t  s4_meta_reg;
    total_t s4_min_reg [NUM_GROUPS];

    always_ff @(posedge aclk) begin
        if (s4_ready && s3_valid_reg) begin
            s4_meta_reg <= s3_meta_reg;
            s4_min_reg  <= group_min;
        end
    end

    // Stage 5: final minimum, saturate, override on count mismatch or bad block count
    total_t                best_total;
    logic [SCORE_W-1:0]    score;

    always_comb begin
        best_total = s4_min_reg[0];
        for (int g = 1; g < NUM_GROUPS; g++) begin
            if (s4_min_reg[g] < best_total) begin
                best_total = s4_min_reg[g];
            end
        end
        if (s4_meta_reg.no_match || best_total > total_t'(NO_MATCH_SCORE)) begin
            score = NO_MATCH_SCORE;
        end else begin
            score = best_total[SCORE_W-1:0];
        end
    end

    logic               s5_no_match_reg;
    logic [SCORE_W-1:0] s5_score_reg;

    always_ff @(posedge aclk) begin
        if (s5_ready && s4_valid_reg) begin
            s5_no_match_reg <= s4_meta_reg.no_match;
            s5_score_reg    <= score;
        end
    end

    assign m_tvalid = s5_valid_reg;
    assign m_tdata  = s5_score_reg;

    `PMS_ASSERT_IMP(a_no_match_score, aclk, aresetn, s5_valid_reg && s5_no_match_reg, s5_score_reg == NO_MATCH_SCORE, "count mismatch did not score 255")
    `PMS_ASSERT_NEXT(a_s3_hold, aclk, aresetn, s3_valid_reg && !s4_ready, s3_valid_reg && $stable(s3_total_reg[0]) && $stable(s3_meta_reg), "stalled totals changed")
    `PMS_ASSERT_NEXT(a_s4_hold, aclk, aresetn, s4_valid_reg && !s5_ready, s4_valid_reg && $stable(s4_min_reg[0]) && $stable(s4_meta_reg), "stalled group minimum changed")
    `PMS_ASSERT_IMP(a_identity_usable, aclk, aresetn, s3_valid_reg && !s3_meta_reg.no_match, s3_total_reg[0] <= total_t'(NUM_PARTS * BITMAP_W), "identity ordering marked unusable")

endmodule

[design/pms_cost.sv]
// Pairwise Hamming cost matrix: XOR and popcount of every block/entry bitmap pair.
// Two register stages (chunk counts, then full counts). Depends on pms_pkg.
`include "assert_macros.svh"

module pms_cost (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pms_pkg::meta_t       in_meta,
    input  pms_pkg::bitmap_set_t entry_bitmap,
    input  pms_pkg::bitmap_set_t block_bitmap,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pms_pkg::meta_t       out_meta,
    output pms_pkg::cost_mat_t   cost
);
    import pms_pkg::*;

    typedef logic [CHUNK_CNT_W-1:0] chunk_cnt_t;

    function automatic chunk_cnt_t popcount_chunk(input logic [CHUNK_W-1:0] x);
        chunk_cnt_t sum;
        sum = '0;
        for (int b = 0; b < CHUNK_W; b++) begin
            sum = sum + chunk_cnt_t'(x[b]);
        end
        return sum;
    endfunction

    logic       s1_valid_reg, s1_valid_next;
    logic       s2_valid_reg, s2_valid_next;
    logic       s1_ready, s2_ready;
    meta_t      s1_meta_reg, s2_meta_reg;
    chunk_cnt_t s1_chunk_reg [NUM_PARTS][NUM_PARTS][NUM_CHUNKS];
    cost_mat_t  s2_cost_reg;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb begin
        s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Stage 1: XOR and count each 16-bit chunk.
    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_meta_reg <= in_meta;
            for (int i = 0; i < NUM_PARTS; i++) begin
                for (int j = 0; j < NUM_PARTS; j++) begin
                    for (int c = 0; c < NUM_CHUNKS; c++) begin
                        s1_chunk_reg[i][j][c] <= popcount_chunk(
                            block_bitmap[i][c*CHUNK_W +: CHUNK_W] ^
                            entry_bitmap[j][c*CHUNK_W +: CHUNK_W]);
                    end
                end
            end
        end
    end

    // Stage 2: add the chunk counts into one cost per pair.
    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_meta_reg <= s1_meta_reg;
            for (int i = 0; i < NUM_PARTS; i++) begin
                for (int j = 0; j < NUM_PARTS; j++) begin
                    s2_cost_reg[i][j] <= cost_t'(s1_chunk_reg[i][j][0])
                                       + cost_t'(s1_chunk_reg[i][j][1])
                                       + cost_t'(s1_chunk_reg[i][j][2])
                                       + cost_t'(s1_chunk_reg[i][j][3]);
                end
            end
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_meta  = s2_meta_reg;
    assign cost      = s2_cost_reg;

    for (genvar gi = 0; gi < NUM_PARTS; gi++) begin : g_chk_i
        for (genvar gj = 0; gj < NUM_PARTS; gj++) begin : g_chk_j
            `PMS_ASSERT_IMP(a_cost_range, aclk, aresetn, out_valid, s2_cost_reg[gi][gj] <= cost_t'(BITMAP_W), "pair cost exceeds bitmap width")
        end
    end

    `PMS_ASSERT_NEXT(a_s2_hold, aclk, aresetn, s2_valid_reg && !out_ready, s2_valid_reg && $stable(s2_cost_reg), "stalled cost word changed")

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for partition_mismatch_scoring_unit: streams table entries,
// predicts each least-mismatch score and compares every result word in order.
// Depends on pms_pkg and the RTL of the unit; reads no files.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pms_pkg::*;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          DRAIN_CYCLES  = 10;
    localparam int          REPORT_LIMIT  = 10;
    localparam int          IDLE_PERCENT  = 35;
    localparam int          PHASES        = 11;
    localparam bitmap_t     ONES          = {BITMAP_W{1'b1}};
    localparam logic [SCORE_W-1:0] SCORE_CEILING = {SCORE_W{1'b1}};
    // Register indexes past the last bitmap; writes there must be dropped.
    localparam logic [CFG_INDEX_W-1:0] FIRST_UNUSED_REG = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] LAST_UNUSED_REG  = 3'd7;

    typedef struct packed {
        bitmap_set_t           bitmaps;
        logic [PART_CNT_W-1:0] parts;
    } table_entry_t;

    // Holds the clustering copy and the queue of scores still owed by the unit.
    class score_tracker;
        logic [PART_CNT_W-1:0] cfg_parts;
        bitmap_set_t           cfg_bitmaps;
        logic [SCORE_W-1:0]    pending_scores [$];
        int                    failures;

        function new();
            cfg_parts   = MIN_PARTS;
            cfg_bitmaps = '0;
            failures    = 0;
        endfunction

        function void apply_write(logic [CFG_INDEX_W-1:0] idx, bitmap_t value);
            if (idx == REG_BLOCK_PARTITIONS)
                cfg_parts = value[PART_CNT_W-1:0];
            else if (idx <= REG_BLOCK_BITMAP_3)
                cfg_bitmaps[idx - REG_BLOCK_BITMAP_0] = value;
        endfunction

        // Least total popcount over all one-to-one matchings of the first n partitions.
        function logic [SCORE_W-1:0] least_mismatch(table_entry_t e);
            int n;
            int best;
            int sum;
            int pick [NUM_PARTS];
            bit ok;
            n = int'(cfg_parts);
            if (e.parts != cfg_parts || cfg_parts < MIN_PARTS || cfg_parts > MAX_PARTS)
                return NO_MATCH_SCORE;
            best = 1 << 30;
            for (int code = 0; code < (1 << (2 * NUM_PARTS)); code++) begin
                for (int i = 0; i < NUM_PARTS; i++)
                    pick[i] = (code >> (2 * i)) & 3;
                ok = 1'b1;
                for (int i = 0; i < NUM_PARTS; i++) begin
                    if (i < n)
                        ok &= (pick[i] < n);
                    else
                        ok &= (pick[i] == i);
                    for (int j = i + 1; j < NUM_PARTS; j++)
                        if (pick[i] == pick[j])
                            ok = 1'b0;
                end
                if (!ok)
                    continue;
                sum = 0;
                for (int i = 0; i < n; i++)
                    sum += $countones(cfg_bitmaps[i] ^ e.bitmaps[pick[i]]);
                if (sum < best)
                    best = sum;
            end
            return (best > SCORE_CEILING) ? SCORE_CEILING : best[SCORE_W-1:0];
        endfunction

        function void note_entry(table_entry_t e);
            pending_scores.push_back(least_mismatch(e));
        endfunction

        function void check_score(logic [SCORE_W-1:0] got);
            logic [SCORE_W-1:0] want;
            if (pending_scores.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("[%0t] unexpected result word: mismatch_count=%0d", $time, got);
                return;
            end
            want = pending_scores.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("[%0t] mismatch_count: expected %0d, got %0d", $time, want, got);
            end
        endfunction

        function int pending();
            return pending_scores.size();
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_we;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_wdata;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [263:0]               s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [SCORE_W-1:0]         m_tdata;

    score_tracker scores;
    bit           tx_pace;
    bit           rx_pace;
    int           rx_hold;
    int           cycle_count;

    int unsigned  phase_parts [PHASES] = '{2, 3, 4, 4, 2, 3, 6, 4, 3, 2, 4};

    partition_mismatch_scoring_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** partition_mismatch_scoring_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready)
            scores.check_score(m_tdata);

    // Receiver: long hold-offs on request, otherwise random stalls while rx_pace is set.
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_tready <= !(rx_pace && $urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    function automatic bitmap_t rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bitmap_set_t random_set();
        bitmap_set_t b;
        for (int i = 0; i < NUM_PARTS; i++) begin
            case ($urandom_range(9))
                0:       b[i] = '0;
                1:       b[i] = ONES;
                default: b[i] = rand64();
            endcase
        end
        return b;
    endfunction

    // Give each texel to exactly one of the first n clusters; leave the rest as noise.
    function automatic bitmap_set_t random_clustering(int n);
        bitmap_set_t b;
        b = random_set();
        for (int i = 0; i < n; i++)
            b[i] = '0;
        for (int t = 0; t < BITMAP_W; t++)
            b[$urandom_range(n - 1)][t] = 1'b1;
        return b;
    endfunction

    function automatic table_entry_t entry_of(logic [PART_CNT_W-1:0] p, bitmap_set_t b);
        table_entry_t e;
        e.parts   = p;
        e.bitmaps = b;
        return e;
    endfunction

    // Shuffle the block clustering across the first n slots and flip a few texels.
    function automatic table_entry_t related_entry(int n, bitmap_set_t blk, int flips);
        table_entry_t e;
        int slot [NUM_PARTS];
        int j;
        int t;
        for (int i = 0; i < NUM_PARTS; i++)
            slot[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = slot[i];
            slot[i] = slot[j];
            slot[j] = t;
        end
        e.parts   = PART_CNT_W'(n);
        e.bitmaps = random_set();
        for (int i = 0; i < n; i++)
            e.bitmaps[slot[i]] = blk[i];
        for (int f = 0; f < flips; f++)
            e.bitmaps[$urandom_range(n - 1)][$urandom_range(BITMAP_W - 1)] ^= 1'b1;
        return e;
    endfunction

    task automatic send_entry(input table_entry_t e);
        while (tx_pace && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, e};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        scores.note_entry(e);
        @(negedge aclk);
    endtask

    // Hold the input idle until every score has come back, then let the pipe settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (scores.pending() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input bitmap_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        scores.apply_write(idx, value);
        @(negedge aclk);
    endtask

    task automatic apply_config(input logic [PART_CNT_W-1:0] n, input bitmap_set_t blk);
        write_reg(REG_BLOCK_PARTITIONS, bitmap_t'(n));
        for (int i = 0; i < NUM_PARTS; i++)
            write_reg(CFG_INDEX_W'(REG_BLOCK_BITMAP_0 + i), blk[i]);
        // Stray write past the register file; must not disturb anything.
        write_reg(CFG_INDEX_W'($urandom_range(LAST_UNUSED_REG, FIRST_UNUSED_REG)), rand64());
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        bitmap_set_t                blk;
        logic [PART_CNT_W-1:0]      n;
        logic [PART_CNT_W-1:0]      bad_counts [4];
        int                         items;
        int                         r;

        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        tx_pace     = 1'b1;
        rx_pace     = 1'b1;
        rx_hold     = 0;
        cycle_count = 0;
        scores      = new();

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset clustering: two partitions, both bitmaps empty.
        send_entry(entry_of(3'd2, {NUM_PARTS{ONES}}));
        send_entry(entry_of(3'd2, '0));
        for (int p = 0; p < 8; p++)
            if (p != 2)
                send_entry(entry_of(PART_CNT_W'(p), random_set()));
        wait_drained();

        // Overlapping clusters: totals above the score range saturate.
        apply_config(MAX_PARTS, {NUM_PARTS{ONES}});
        send_entry(entry_of(MAX_PARTS, '0));
        send_entry(entry_of(MAX_PARTS, {NUM_PARTS{ONES}}));
        send_entry(entry_of(MAX_PARTS, {ONES, bitmap_t'(0), ONES, ONES}));
        wait_drained();

        blk = random_clustering(3);
        apply_config(3'd3, blk);
        send_entry(related_entry(3, blk, 0));
        send_entry(related_entry(3, blk, 3));
        send_entry(entry_of(MAX_PARTS, blk));
        wait_drained();

        // Configured counts outside 2..4 score no match even for an equal entry count.
        bad_counts = '{3'd7, 3'd0, 3'd1, 3'd5};
        foreach (bad_counts[k]) begin
            blk = random_clustering(NUM_PARTS);
            apply_config(bad_counts[k], blk);
            send_entry(entry_of(bad_counts[k], blk));
            wait_drained();
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            n = PART_CNT_W'(phase_parts[ph]);
            if (ph == 4)
                blk = {bitmap_t'(0), ONES, bitmap_t'(0), ONES};
            else if (ph == 9)
                blk = {ONES, ONES, ONES, bitmap_t'(0)};
            else if (n >= MIN_PARTS && n <= MAX_PARTS)
                blk = random_clustering(int'(n));
            else
                blk = random_set();
            apply_config(n, blk);

            items = (ph == 6) ? 20 : (ph == 2) ? 90 : 50;
            tx_pace = (ph != 2);
            rx_pace = (ph != 2);
            if (ph == 5)
                rx_hold = 150;
            else if (ph == 8)
                rx_hold = 100;

            for (int k = 0; k < items; k++) begin
                r = $urandom_range(99);
                if (n < MIN_PARTS || n > MAX_PARTS)
                    send_entry(entry_of(r < 50 ? n : PART_CNT_W'($urandom_range(7)),
                                        random_set()));
                else if (r < 70)
                    send_entry(related_entry(int'(n), blk, $urandom_range(8)));
                else if (r < 85)
                    send_entry(entry_of(n, random_set()));
                else
                    send_entry(entry_of(PART_CNT_W'($urandom_range(7)), random_set()));
            end
            wait_drained();
        end

        tx_pace = 1'b1;
        rx_pace = 1'b1;
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (scores.failures == 0 && scores.pending() == 0)
            $display("** partition_mismatch_scoring_unit: PASSED **");
        else
            $display("** partition_mismatch_scoring_unit: FAILED **");
        $finish;
    end

endmodule
